// File: hw/rtl/ebq_pkg.sv
// Shared types and constants for the encoder and button qualifier.
// No dependencies; used by every module under hw/rtl.
package ebq_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST = 16'd40;
    localparam logic [CFG_W-1:0] HOLD_MS_RST     = 16'd700;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MS     = 2'd1;

    typedef struct packed {
        logic held;
        logic clicked;
    } t_key_evt;

    typedef struct packed {
        logic right;
        logic left;
    } t_step_evt;

endpackage

// File: hw/rtl/encoder_and_button_qualifier.sv
// Top level of the rotary encoder and two-button qualifier.
// Depends on ebq_pkg, ebq_step and ebq_key.
//
// Channel   Dir  Handshake                    Payload (low bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready  now_ms[31:0], line_a, line_b,
//                                             enc_switch, button_level, pad
// m_axis    out  m_axis_tvalid/m_axis_tready  step_left, step_right, enc_clicked,
//                                             enc_held, button_clicked, button_held
// cfg       in   i_cfg_we                     index 0 debounce_ms, 1 hold_ms
//
// One transaction per cycle sustained while m_axis_tready stays high. A
// transaction is captured in an input register, evaluated against the key and
// encoder state, and its event bits land in the result register, after which
// m_axis_tvalid rises (two register stages).
// The state update happens on the move from the input to the result register,
// so a stall on m_axis freezes both stages and s_axis_tready drops only when
// both are full. Reset is synchronous; it empties both stages, restores the
// initial pin levels and reloads debounce_ms = 40, hold_ms = 700.
module encoder_and_button_qualifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [ebq_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [ebq_pkg::CFG_W-1:0]          i_cfg_data,
    // sample stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_ms[31:0], line_a[32], line_b[33], enc_switch[34], button_level[35]
    input  logic [ebq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // event stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // step_left[0], step_right[1], enc_clicked[2], enc_held[3],
    // button_clicked[4], button_held[5]
    output logic [ebq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic [ebq_pkg::CFG_W-1:0]  r_debounce_ms;
    logic [ebq_pkg::CFG_W-1:0]  r_hold_ms;

    // input register
    logic                       r_in_valid;
    logic [ebq_pkg::TIME_W-1:0] r_now_ms;
    logic                       r_line_a;
    logic                       r_line_b;
    logic                       r_enc_switch;
    logic                       r_button_level;

    // result register
    logic                       r_out_valid;
    logic [5:0]                 r_out_bits;
    logic [5:0]                 n_out_bits;

    logic                       out_free;
    logic                       advance;
    logic                       in_take;

    ebq_pkg::t_step_evt         step_evt;
    ebq_pkg::t_key_evt          enc_evt;
    ebq_pkg::t_key_evt          btn_evt;

    // the result register takes a new item when empty or being drained
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ebq_pkg::OUT_TDATA_W-6){1'b0}}, r_out_bits};

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= ebq_pkg::DEBOUNCE_MS_RST;
            r_hold_ms     <= ebq_pkg::HOLD_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ebq_pkg::CFG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_data;
                ebq_pkg::CFG_HOLD_MS:     r_hold_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage: control with reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now_ms       <= s_axis_tdata[31:0];
            r_line_a       <= s_axis_tdata[32];
            r_line_b       <= s_axis_tdata[33];
            r_enc_switch   <= s_axis_tdata[34];
            r_button_level <= s_axis_tdata[35];
        end
    end

    ebq_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_line_a  (r_line_a),
        .i_line_b  (r_line_b),
        .o_evt     (step_evt)
    );

    ebq_key u_enc_key (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_raw         (r_enc_switch),
        .i_now_ms      (r_now_ms),
        .i_debounce_ms (r_debounce_ms),
        .i_hold_ms     (r_hold_ms),
        .o_evt         (enc_evt)
    );

    ebq_key u_btn_key (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_raw         (r_button_level),
        .i_now_ms      (r_now_ms),
        .i_debounce_ms (r_debounce_ms),
        .i_hold_ms     (r_hold_ms),
        .o_evt         (btn_evt)
    );

    assign n_out_bits = {btn_evt.held, btn_evt.clicked, enc_evt.held, enc_evt.clicked,
                         step_evt.right, step_evt.left};

    // result stage: load on advance, drop once taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_bits <= n_out_bits;
        end
    end

`ifndef SYNTHESIS
    // a single sample cannot step both ways
    a_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("step_left and step_right both set");

    // click and hold of the same key are exclusive
    a_key_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[3])
                       && !(m_axis_tdata[4] && m_axis_tdata[5]))
        else $error("click and hold reported together");

    // a full input stage with a stalled result stage must block new samples
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full");

    // every advanced item shows up as a valid result on the next cycle
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced item did not reach the result register");
`endif

endmodule

// File: hw/rtl/ebq_key.sv
// Lockout debouncer with click / hold qualification for one button.
// Depends on ebq_pkg.
module ebq_key (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_raw,
    input  logic [ebq_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [ebq_pkg::CFG_W-1:0]   i_debounce_ms,
    input  logic [ebq_pkg::CFG_W-1:0]   i_hold_ms,
    output ebq_pkg::t_key_evt           o_evt
);

    logic                       r_stable, n_stable;
    logic                       r_pressed, n_pressed;
    logic [ebq_pkg::TIME_W-1:0] r_press_start, n_press_start;
    logic [ebq_pkg::TIME_W-1:0] r_last_change, n_last_change;
    logic [ebq_pkg::TIME_W-1:0] since_change;
    logic [ebq_pkg::TIME_W-1:0] since_press;
    logic [ebq_pkg::TIME_W-1:0] debounce_ext;
    logic [ebq_pkg::TIME_W-1:0] hold_ext;

    assign since_change = i_now_ms - r_last_change;
    assign since_press  = i_now_ms - r_press_start;
    assign debounce_ext = {{(ebq_pkg::TIME_W-ebq_pkg::CFG_W){1'b0}}, i_debounce_ms};
    assign hold_ext     = {{(ebq_pkg::TIME_W-ebq_pkg::CFG_W){1'b0}}, i_hold_ms};

    always_comb begin
        n_stable      = r_stable;
        n_pressed     = r_pressed;
        n_press_start = r_press_start;
        n_last_change = r_last_change;
        o_evt         = '0;
        if (i_raw != r_stable) begin
            // accept a new level only once the lockout has run out
            if (since_change > debounce_ext) begin
                n_stable      = i_raw;
                n_last_change = i_now_ms;
                if (!i_raw) begin
                    n_pressed     = 1'b1;
                    n_press_start = i_now_ms;
                end else if (r_pressed) begin
                    o_evt.clicked = (since_press < hold_ext);
                    n_pressed     = 1'b0;
                end
            end
        end else if (r_pressed && (since_press > hold_ext)) begin
            o_evt.held = 1'b1;
            n_pressed  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= 1'b1;
            r_pressed     <= 1'b0;
            r_press_start <= '0;
            r_last_change <= '0;
        end else if (i_advance) begin
            r_stable      <= n_stable;
            r_pressed     <= n_pressed;
            r_press_start <= n_press_start;
            r_last_change <= n_last_change;
        end
    end

endmodule

// File: hw/rtl/ebq_step.sv
// Quadrature step detector: falling edge on A, direction from B.
// Depends on ebq_pkg.
module ebq_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_line_a,
    input  logic              i_line_b,
    output ebq_pkg::t_step_evt o_evt
);

    logic r_prev_a;

    assign o_evt.right = r_prev_a && !i_line_a && i_line_b;
    assign o_evt.left  = r_prev_a && !i_line_a && !i_line_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b1;
        end else if (i_advance) begin
            r_prev_a <= i_line_a;
        end
    end

endmodule
